// ===== design/fbpa_pkg.sv =====
// Shared constants for the fixed block pool allocator: widths, codes, beat layouts.
`default_nettype none

package fbpa_pkg;

    // Pool size default
    localparam int MAX_BLOCKS_DEF = 1024;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int BYTES_W = 13;
    localparam int OFF_W   = 22;

    // Operation codes carried in tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

    // Configuration reset values and limits
    localparam logic [CNT_W-1:0]   BLOCK_COUNT_RST = 11'd10;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 13'd64;
    localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 13'd8;
    localparam logic [CNT_W-1:0]   USED_LIMIT      = 11'h7FF;

    // Input beat layout (tdata)
    localparam int IN_W        = 16;
    localparam int IN_IDX_LO   = 0;
    localparam int IN_NULL_BIT = 10;

    // Output beat layout (tdata)
    localparam int OUT_W         = 48;
    localparam int OUT_GRANT_BIT = 0;
    localparam int OUT_IDX_LO    = 1;
    localparam int OUT_OFF_LO    = 11;
    localparam int OUT_RECYC_BIT = 33;
    localparam int OUT_EXH_BIT   = 34;
    localparam int OUT_USED_LO   = 35;

endpackage

`default_nettype wire

// ===== design/fbpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/fixed_block_pool_allocator.sv =====
// Fixed-size block allocator: LIFO free list in a link RAM plus a bump counter.
//
// Usage: one request beat on s_axis (tuser selects allocate or free, tdata
// carries the freed index and a null flag) gives exactly one result beat on
// m_axis (grant flag, block index, byte offset, source, exhaustion flag and
// the used count after the operation). Configuration (block_count,
// block_bytes) is written through cfg_we/cfg_index/cfg_data; the user must write
// it only while idle, as the block itself does not enforce this. The result is
// registered and appears in the cycle after the request beat. A free, a fresh
// or an exhausted allocate leaves the block idle; an allocate that pops the
// free list waits in ST_POP until the new list head from the link RAM is loaded.
// Reset: the free list is empty, the fresh and used counts are zero,
// block_count is 10 and block_bytes is 64; the link RAM is not cleared,
// as an entry is only read after a free has written it.
// Stall: the result register holds while m_axis_tready is low; a new request
// is taken only when idle and that register is empty or drains in the same cycle.
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request: tuser = func
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic                           s_axis_tuser,
    // request: tdata = free_index[9:0], free_is_null[10], zero pad
    input  wire logic [fbpa_pkg::IN_W-1:0]      s_axis_tdata,
    // result: tdata = granted[0], block_index[10:1], byte_offset[32:11],
    //         from_free_list[33], exhausted[34], used_blocks[45:35], zero pad
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [fbpa_pkg::OUT_W-1:0]          m_axis_tdata,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fbpa_pkg::BYTES_W-1:0]   cfg_data
);

    localparam int AW     = $clog2(MAX_BLOCKS);
    localparam int PW     = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = PW + fbpa_pkg::BYTES_W;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t                           state_reg;
    logic [PW-1:0]                    head_reg;
    logic [PW-1:0]                    fresh_reg;
    logic [fbpa_pkg::CNT_W-1:0]       used_reg;
    logic [fbpa_pkg::CNT_W-1:0]       block_count_reg;
    logic [fbpa_pkg::BYTES_W-1:0]     block_bytes_reg;
    logic                             out_valid_reg;
    logic [fbpa_pkg::OUT_W-1:0]       out_data_reg;

    logic [fbpa_pkg::OUT_W-1:0]       out_data_next;
    logic [PW-1:0]                    head_next;

    logic                             accept;
    logic                             is_alloc;
    logic [fbpa_pkg::IDX_W-1:0]       free_index;
    logic                             free_is_null;
    logic                             list_nonempty;
    logic                             fresh_ok;
    logic                             free_ok;
    logic                             grant;
    logic                             pop;
    logic                             exhausted;
    logic [PW-1:0]                    got;
    logic [fbpa_pkg::BYTES_W-1:0]     size;
    logic [PROD_W-1:0]                prod;
    logic [fbpa_pkg::OFF_W-1:0]       offset;
    logic [fbpa_pkg::IDX_W-1:0]       grant_index;
    logic [fbpa_pkg::CNT_W-1:0]       used_after;
    logic [PW-1:0]                    link_rdata;

    // Unpack request beat
    assign free_index   = s_axis_tdata[fbpa_pkg::IN_IDX_LO +: fbpa_pkg::IDX_W];
    assign free_is_null = s_axis_tdata[fbpa_pkg::IN_NULL_BIT];
    assign is_alloc     = (s_axis_tuser == fbpa_pkg::FUNC_ALLOC);

    // Take a request only when idle and the result register is free or draining
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Pick the block source
    assign list_nonempty = (32'(head_reg) < 32'(MAX_BLOCKS));
    assign fresh_ok      = (32'(fresh_reg) < 32'(block_count_reg))
                           && (32'(fresh_reg) < 32'(MAX_BLOCKS));
    assign free_ok       = !free_is_null && (32'(free_index) < 32'(MAX_BLOCKS));
    assign grant         = is_alloc && (list_nonempty || fresh_ok);
    assign pop           = is_alloc && list_nonempty;
    assign exhausted     = is_alloc && !grant;
    assign got           = list_nonempty ? head_reg : fresh_reg;

    // Byte offset of the granted block
    assign size   = (block_bytes_reg < fbpa_pkg::MIN_BLOCK_BYTES)
                    ? fbpa_pkg::MIN_BLOCK_BYTES : block_bytes_reg;
    assign prod   = PROD_W'(got) * PROD_W'(size);
    assign offset = grant ? fbpa_pkg::OFF_W'(prod) : '0;
    assign grant_index = grant ? fbpa_pkg::IDX_W'(got) : '0;

    // Saturating used count
    always_comb
    begin
        used_after = used_reg;
        if (grant && (used_reg != fbpa_pkg::USED_LIMIT))
        begin
            used_after = used_reg + 1'b1;
        end
        else if (!is_alloc && free_ok && (used_reg != '0))
        begin
            used_after = used_reg - 1'b1;
        end
    end

    // Pack result beat
    always_comb
    begin
        out_data_next = '0;
        out_data_next[fbpa_pkg::OUT_GRANT_BIT]                      = grant;
        out_data_next[fbpa_pkg::OUT_IDX_LO +: fbpa_pkg::IDX_W]      = grant_index;
        out_data_next[fbpa_pkg::OUT_OFF_LO +: fbpa_pkg::OFF_W]      = offset;
        out_data_next[fbpa_pkg::OUT_RECYC_BIT]                      = pop;
        out_data_next[fbpa_pkg::OUT_EXH_BIT]                        = exhausted;
        out_data_next[fbpa_pkg::OUT_USED_LO +: fbpa_pkg::CNT_W]     = used_after;
    end

    // New head after a pop, clamped to the empty marker
    assign head_next = (32'(link_rdata) > 32'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : link_rdata;

    // Link RAM: push writes the old head, pop reads the head's link
    fbpa_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (accept && !is_alloc && free_ok),
        .waddr (AW'(free_index)),
        .wdata (head_reg),
        .raddr (head_reg[AW-1:0]),
        .rdata (link_rdata)
    );

    // State, counters, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= PW'(MAX_BLOCKS);
            fresh_reg       <= '0;
            used_reg        <= '0;
            block_count_reg <= fbpa_pkg::BLOCK_COUNT_RST;
            block_bytes_reg <= fbpa_pkg::BLOCK_BYTES_RST;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fbpa_pkg::CFG_BLOCK_COUNT: block_count_reg <= cfg_data[fbpa_pkg::CNT_W-1:0];
                    fbpa_pkg::CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
                used_reg      <= used_after;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (pop)
                        begin
                            state_reg <= ST_POP;
                        end
                        else if (grant)
                        begin
                            fresh_reg <= fresh_reg + 1'b1;
                        end
                        else if (!is_alloc && free_ok)
                        begin
                            head_reg <= PW'(free_index);
                        end
                    end
                end
                ST_POP:
                begin
                    head_reg  <= head_next;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/fbpa_checker.sv =====
// Port-level checker for the fixed block pool allocator, bound to the top level.
`default_nettype none

module fbpa_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [fbpa_pkg::OUT_W-1:0]     m_axis_tdata
);

    logic out_grant;
    logic out_recyc;
    logic out_exh;

    assign out_grant = m_axis_tdata[fbpa_pkg::OUT_GRANT_BIT];
    assign out_recyc = m_axis_tdata[fbpa_pkg::OUT_RECYC_BIT];
    assign out_exh   = m_axis_tdata[fbpa_pkg::OUT_EXH_BIT];

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Never take a request that would overwrite a waiting result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("request accepted over a stalled result");

    // Every request beat yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after an accepted request");

    // A refused or free result carries no block
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_grant |->
            !out_recyc
            && (m_axis_tdata[fbpa_pkg::OUT_IDX_LO +: fbpa_pkg::IDX_W] == '0)
            && (m_axis_tdata[fbpa_pkg::OUT_OFF_LO +: fbpa_pkg::OFF_W] == '0))
        else $error("block fields set without a grant");

    // Grant and exhaustion exclude each other
    a_grant_exh: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_grant && out_exh))
        else $error("grant and exhaustion both set");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
